// ===== src/binomial_divisibility_run_finder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// binomial_divisibility_run_finder_unit_assert.svh
// assertion macros used by the run finder port checker
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_DIVISIBILITY_RUN_FINDER_UNIT_ASSERT_SVH
`define BINOMIAL_DIVISIBILITY_RUN_FINDER_UNIT_ASSERT_SVH

// same-cycle implication
`define BDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/bdr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdr_pkg
// types, codes and microcode layout of the binomial divisibility run finder
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CfgIdxWidth = 1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DIGIT_BASE = 1'b0,
    CFG_TOP_VALUE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_INIT  = 3'd2,
    OP_DSTEP = 3'd3,
    OP_CHECK = 3'd4,
    OP_EMIT  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    COND_IN_VALID  = 3'd0,
    COND_BOTH_ZERO = 3'd1,
    COND_CNT_LAST  = 3'd2,
    COND_DIGIT_GT  = 3'd3,
    COND_OUT_FREE  = 3'd4
  } cond_e;

  typedef enum logic [2:0] {
    STEP_WAIT = 3'd0,
    STEP_TEST = 3'd1,
    STEP_DIV  = 3'd2,
    STEP_CMP  = 3'd3,
    STEP_EMIT = 3'd4
  } step_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e jmp_true;
    step_e jmp_false;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic both_zero;
    logic cnt_last;
    logic digit_gt;
    logic out_free;
  } status_t;

endpackage

// ===== src/bdr_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// bdr_ucode_rom
// control store: one control word per step of the digit test program
// ----------------------------------------------------------------------------
module bdr_ucode_rom (
  input  bdr_pkg::step_e  addr_i,
  output bdr_pkg::uword_t word_o
);

  always_comb begin
    case (addr_i)
      bdr_pkg::STEP_WAIT: begin
        word_o = '{bdr_pkg::OP_LOAD, bdr_pkg::COND_IN_VALID,
                   bdr_pkg::STEP_TEST, bdr_pkg::STEP_WAIT};
      end
      bdr_pkg::STEP_TEST: begin
        word_o = '{bdr_pkg::OP_INIT, bdr_pkg::COND_BOTH_ZERO,
                   bdr_pkg::STEP_EMIT, bdr_pkg::STEP_DIV};
      end
      bdr_pkg::STEP_DIV: begin
        word_o = '{bdr_pkg::OP_DSTEP, bdr_pkg::COND_CNT_LAST,
                   bdr_pkg::STEP_CMP, bdr_pkg::STEP_DIV};
      end
      bdr_pkg::STEP_CMP: begin
        word_o = '{bdr_pkg::OP_CHECK, bdr_pkg::COND_DIGIT_GT,
                   bdr_pkg::STEP_EMIT, bdr_pkg::STEP_TEST};
      end
      bdr_pkg::STEP_EMIT: begin
        word_o = '{bdr_pkg::OP_EMIT, bdr_pkg::COND_OUT_FREE,
                   bdr_pkg::STEP_WAIT, bdr_pkg::STEP_EMIT};
      end
      default: begin
        word_o = '{bdr_pkg::OP_NONE, bdr_pkg::COND_IN_VALID,
                   bdr_pkg::STEP_WAIT, bdr_pkg::STEP_WAIT};
      end
    endcase
  end

endmodule

// ===== src/bdr_seq.sv =====
// ----------------------------------------------------------------------------
// bdr_seq
// step counter with conditional jumps over the control store
// ----------------------------------------------------------------------------
module bdr_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bdr_pkg::status_t status_i,
  output bdr_pkg::ctrl_t   ctrl_o,
  output logic             in_ready_o
);

  bdr_pkg::step_e  pc_q, pc_d;
  bdr_pkg::uword_t word;
  logic            go;

  bdr_ucode_rom u_rom (
    .addr_i (pc_q),
    .word_o (word)
  );

  always_comb begin
    case (word.cond)
      bdr_pkg::COND_IN_VALID:  go = in_valid_i;
      bdr_pkg::COND_BOTH_ZERO: go = status_i.both_zero;
      bdr_pkg::COND_CNT_LAST:  go = status_i.cnt_last;
      bdr_pkg::COND_DIGIT_GT:  go = status_i.digit_gt;
      bdr_pkg::COND_OUT_FREE:  go = status_i.out_free;
      default:                 go = 1'b0;
    endcase
  end

  assign pc_d       = go ? word.jmp_true : word.jmp_false;
  assign ctrl_o     = '{word.op, go};
  assign in_ready_o = (pc_q == bdr_pkg::STEP_WAIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bdr_pkg::STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== src/bdr_dpath.sv =====
// ----------------------------------------------------------------------------
// bdr_dpath
// config registers, twin restoring dividers, digit compare, run tracking
// ----------------------------------------------------------------------------
module bdr_dpath #(
  parameter int unsigned VALUE_WIDTH = bdr_pkg::ValueWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bdr_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]              cfg_wdata_i,
  input  bdr_pkg::ctrl_t                      ctrl_i,
  input  logic [VALUE_WIDTH-1:0]              sweep_value_i,
  input  logic                                final_item_i,
  input  logic                                out_ready_i,
  output bdr_pkg::status_t                    status_o,
  output logic                                out_valid_o,
  output logic                                divides_o,
  output logic                                run_closed_o,
  output logic [VALUE_WIDTH-1:0]              run_first_o,
  output logic [VALUE_WIDTH-1:0]              run_last_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] MinBase = VALUE_WIDTH'(2);

  logic [VALUE_WIDTH-1:0] base_cfg_q, top_cfg_q;
  logic [VALUE_WIDTH-1:0] p_q, t_q, m_q, t_orig_q, run_begin_q;
  logic [VALUE_WIDTH:0]   rt_q, rm_q;
  logic [CntWidth-1:0]    cnt_q;
  logic                   hit_q, fin_q, in_run_q, out_valid_q;
  logic                   divides_q, run_closed_q;
  logic [VALUE_WIDTH-1:0] run_first_q, run_last_q;

  logic [VALUE_WIDTH:0]   p_ext, rt_sh, rm_sh, rt_nx, rm_nx;
  logic                   rt_ge, rm_ge;
  logic                   out_free, do_emit;
  logic                   closed_miss, closed_fin, closed;
  logic [VALUE_WIDTH-1:0] begin_eff, first_d, last_d;

  // one restoring step on both dividends
  assign p_ext = {1'b0, p_q};
  assign rt_sh = {rt_q[VALUE_WIDTH-1:0], t_q[VALUE_WIDTH-1]};
  assign rm_sh = {rm_q[VALUE_WIDTH-1:0], m_q[VALUE_WIDTH-1]};
  assign rt_ge = (rt_sh >= p_ext);
  assign rm_ge = (rm_sh >= p_ext);
  assign rt_nx = rt_ge ? (rt_sh - p_ext) : rt_sh;
  assign rm_nx = rm_ge ? (rm_sh - p_ext) : rm_sh;

  // run bookkeeping for the finished item
  assign begin_eff   = (hit_q && !in_run_q) ? t_orig_q : run_begin_q;
  assign closed_miss = !hit_q && in_run_q;
  assign closed_fin  = fin_q && hit_q;
  assign closed      = closed_miss || closed_fin;
  assign first_d     = closed ? begin_eff : '0;
  assign last_d      = closed_fin  ? top_cfg_q :
                       closed_miss ? (t_orig_q - VALUE_WIDTH'(1)) : '0;

  assign out_free = !out_valid_q || out_ready_i;
  assign do_emit  = (ctrl_i.op == bdr_pkg::OP_EMIT) && ctrl_i.go;

  assign status_o = '{
    both_zero: (t_q == '0) && (m_q == '0),
    cnt_last:  (cnt_q == '0),
    digit_gt:  (rt_q > rm_q),
    out_free:  out_free
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_cfg_q  <= MinBase;
      top_cfg_q   <= '0;
      in_run_q    <= 1'b0;
      run_begin_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (bdr_pkg::cfg_idx_e'(cfg_idx_i))
          bdr_pkg::CFG_DIGIT_BASE: base_cfg_q <= cfg_wdata_i;
          bdr_pkg::CFG_TOP_VALUE:  top_cfg_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (do_emit) begin
        in_run_q    <= hit_q && !fin_q;
        run_begin_q <= begin_eff;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      bdr_pkg::OP_LOAD: begin
        if (ctrl_i.go) begin
          t_q      <= sweep_value_i;
          t_orig_q <= sweep_value_i;
          m_q      <= top_cfg_q;
          p_q      <= (base_cfg_q < MinBase) ? MinBase : base_cfg_q;
          fin_q    <= final_item_i;
          hit_q    <= 1'b0;
        end
      end
      bdr_pkg::OP_INIT: begin
        rt_q  <= '0;
        rm_q  <= '0;
        cnt_q <= CntMax;
      end
      bdr_pkg::OP_DSTEP: begin
        rt_q  <= rt_nx;
        rm_q  <= rm_nx;
        t_q   <= {t_q[VALUE_WIDTH-2:0], rt_ge};
        m_q   <= {m_q[VALUE_WIDTH-2:0], rm_ge};
        cnt_q <= cnt_q - CntWidth'(1);
      end
      bdr_pkg::OP_CHECK: begin
        if (ctrl_i.go) begin
          hit_q <= 1'b1;
        end
      end
      bdr_pkg::OP_EMIT: begin
        if (ctrl_i.go) begin
          divides_q    <= hit_q;
          run_closed_q <= closed;
          run_first_q  <= first_d;
          run_last_q   <= last_d;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign divides_o    = divides_q;
  assign run_closed_o = run_closed_q;
  assign run_first_o  = run_first_q;
  assign run_last_o   = run_last_q;

endmodule

// ===== src/binomial_divisibility_run_finder_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_divisibility_run_finder_unit
// base-p digit comparison of t against m with tracking of runs of hits
// ----------------------------------------------------------------------------
// operation: for each base-p digit both t and m are divided by p in a bit-serial
//   restoring divider; an item ends once a digit of t exceeds that of m or both are
//   zero, and its result waits until the output register is free
// one item at a time: the next beat waits until the result has been emitted
// reset: no open run, digit_base = 2, top_value = 0, output register empty
module binomial_divisibility_run_finder_unit #(
  parameter int unsigned VALUE_WIDTH = bdr_pkg::ValueWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdr_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]          cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [VALUE_WIDTH-1:0]          sweep_value_i,
  input  logic                            final_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            divides_o,
  output logic                            run_closed_o,
  output logic [VALUE_WIDTH-1:0]          run_first_o,
  output logic [VALUE_WIDTH-1:0]          run_last_o
);

  bdr_pkg::ctrl_t   ctrl;
  bdr_pkg::status_t status;

  bdr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  bdr_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ctrl_i        (ctrl),
    .sweep_value_i (sweep_value_i),
    .final_item_i  (final_item_i),
    .out_ready_i   (out_ready_i),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .divides_o     (divides_o),
    .run_closed_o  (run_closed_o),
    .run_first_o   (run_first_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ===== src/bdr_port_checker.sv =====
// ----------------------------------------------------------------------------
// bdr_port_checker
// port-level checks of the run finder, bound to the top level
// ----------------------------------------------------------------------------
`include "binomial_divisibility_run_finder_unit_assert.svh"

module bdr_port_checker #(
  parameter int unsigned VALUE_WIDTH = bdr_pkg::ValueWidth
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   run_closed_o,
  input logic [VALUE_WIDTH-1:0] run_first_o,
  input logic [VALUE_WIDTH-1:0] run_last_o
);

  // a pending result beat stays until taken
  `BDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // one item at a time: ready drops after an input beat
  `BDR_ASSERT_NEXT(a_in_single, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // no result beat can appear right after an input beat
  `BDR_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && in_ready_o, !$rose(out_valid_o))

  // bounds are zero unless a run closes
  `BDR_ASSERT_NOW(a_zero_bounds, clk_i, rst_ni, out_valid_o && !run_closed_o, (run_first_o == '0) && (run_last_o == '0))

endmodule

bind binomial_divisibility_run_finder_unit bdr_port_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_bdr_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .run_closed_o (run_closed_o),
  .run_first_o  (run_first_o),
  .run_last_o   (run_last_o)
);
